[design/vrp_pkg.sv]
// Shared types and constants for the vertex rotate, project and viewport unit.
package vrp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_YZ        = 3'd0,
		REG_SIN_YZ        = 3'd1,
		REG_COS_XZ        = 3'd2,
		REG_SIN_XZ        = 3'd3,
		REG_DEPTH_SHIFT   = 3'd4,
		REG_SCREEN_WIDTH  = 3'd5,
		REG_SCREEN_HEIGHT = 3'd6
	} cfg_reg_t;

	localparam int TRIG_W   = 16;
	localparam int SCREEN_W = 13;

	localparam logic signed [TRIG_W-1:0] RST_COS   = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] RST_SIN   = 16'sd0;
	localparam logic signed [TRIG_W-1:0] RST_DEPTH = 16'sd12288;
	localparam logic [SCREEN_W-1:0]      RST_WIDTH  = 13'd640;
	localparam logic [SCREEN_W-1:0]      RST_HEIGHT = 13'd480;

	// sqrt(3) in Q16: focal factor for a 60 degree field of view.
	localparam logic [16:0] FOCAL_Q16 = 17'd113512;
	localparam int FH_W = 30;

	localparam int TRIG_FRAC = 14;
	localparam int NORM_BITS = 25;
	localparam int QUOT_BITS = 26;
	localparam int OUT_W     = 24;
	localparam int OUT_MAX   = 8388607;
	localparam int OUT_MIN   = -8388608;

endpackage

[design/vrp_if.sv]
// Request channels for vertices in and screen positions out.
interface vrp_vtx_if #(parameter int COORD_WIDTH = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vert_x;
	logic signed [COORD_WIDTH-1:0] vert_y;
	logic signed [COORD_WIDTH-1:0] vert_z;

	modport source (output valid, output vert_x, output vert_y, output vert_z, input ready);
	modport sink (input valid, input vert_x, input vert_y, input vert_z, output ready);
endinterface

interface vrp_pix_if
	import vrp_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] screen_x;
	logic signed [OUT_W-1:0] screen_y;
	logic                    behind_camera;

	modport source (output valid, output screen_x, output screen_y, output behind_camera,
		input ready);
	modport sink (input valid, input screen_x, input screen_y, input behind_camera,
		output ready);
endinterface

[design/vertex_rotate_project_viewport_unit.sv]
// Vertex rotation, perspective projection and viewport mapping pipeline.
// Throughput is one vertex per cycle while the output register is not held.
// There are 38 register stages, 27 of them in the restoring divider.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
module vertex_rotate_project_viewport_unit
	import vrp_pkg::*;
#(
	parameter int COORD_WIDTH      = 16,
	parameter int SCREEN_FRAC_BITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vrp_vtx_if.sink               vtx,
	vrp_pix_if.source             pix
);

	localparam int CW  = COORD_WIDTH;
	localparam int S   = SCREEN_FRAC_BITS;
	localparam int P1W = CW + TRIG_W;
	localparam int R1W = CW + 18;
	localparam int Y1W = CW + 3;
	localparam int P2W = Y1W + TRIG_W;
	localparam int R2W = CW + 21;
	localparam int ZW  = CW + 6;
	localparam int EW  = (ZW + 1 > NORM_BITS + 1) ? ZW + 1 : NORM_BITS + 1;
	localparam int NSH = (ZW > NORM_BITS - 2) ? ZW - (NORM_BITS - 2) : 0;
	localparam int NW  = NORM_BITS;
	localparam int MW  = FH_W + 1 + NW;
	localparam int SW  = MW + S + 1;
	localparam int PW  = SW - 17;
	localparam int DW  = (PW > NW - 1 + QUOT_BITS) ? PW : NW - 1 + QUOT_BITS;
	localparam int QB  = QUOT_BITS;
	localparam int QW  = QB + 2;
	localparam int BW  = SCREEN_W + 1 + S;
	localparam int FW  = ((QW > BW) ? QW : BW) + 2;
	localparam int RND = 1 << (TRIG_FRAC - 1);
	localparam int LIM = 1 << (NW - 1);
	localparam int QLIM = 1 << QB;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] q;
		logic          neg;
		logic          ovf;
	} div_lane_t;

	function automatic logic lim_ok(input logic signed [ZW-1:0] v, input int k);
		logic signed [EW-1:0] t;
		t = EW'(v) >>> k;
		return (t < EW'(LIM)) && (t > -EW'(LIM));
	endfunction

	function automatic div_lane_t div_init(input logic [PW-1:0] m, input logic neg,
		input logic [NW-2:0] z);
		div_lane_t d;
		d.rem = DW'(m);
		d.q   = '0;
		d.neg = neg;
		d.ovf = DW'(m) >= (DW'(z) << QB);
		return d;
	endfunction

	function automatic div_lane_t div_step(input div_lane_t d, input logic [NW-2:0] z,
		input int pos);
		div_lane_t r;
		logic [DW-1:0] trial;
		r = d;
		trial = DW'(z) << pos;
		if (d.rem >= trial) begin
			r.rem    = d.rem - trial;
			r.q[pos] = 1'b1;
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [TRIG_W-1:0] cos_yz_q, sin_yz_q, cos_xz_q, sin_xz_q, depth_q;
	logic [SCREEN_W-1:0]      width_q, height_q;
	logic [FH_W-1:0]          fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_yz_q <= RST_COS;
			sin_yz_q <= RST_SIN;
			cos_xz_q <= RST_COS;
			sin_xz_q <= RST_SIN;
			depth_q  <= RST_DEPTH;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COS_YZ:        cos_yz_q <= cfg_data;
				REG_SIN_YZ:        sin_yz_q <= cfg_data;
				REG_COS_XZ:        cos_xz_q <= cfg_data;
				REG_SIN_XZ:        sin_xz_q <= cfg_data;
				REG_DEPTH_SHIFT:   depth_q  <= cfg_data;
				REG_SCREEN_WIDTH:  width_q  <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= cfg_data[SCREEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Focal factor times height; settles long before an item reaches its use.
	always_ff @(posedge clk) begin
		fh_q <= FH_W'(height_q) * FH_W'(FOCAL_Q16);
	end

	logic adv;
	assign adv = !pix.valid || pix.ready;
	assign vtx.ready = adv;

	// Pipeline registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s37, v_s38;
	logic vd_s10 [QB+1];

	logic signed [CW-1:0]  x_s1, x_s2;
	logic signed [P1W-1:0] yc1_s1, zs1_s1, ys1_s1, zc1_s1;
	logic signed [Y1W-1:0] y1_s2, z1_s2, y1_s3;
	logic signed [P1W-1:0] xc2_s3, xs2_s3;
	logic signed [P2W-1:0] z1s2_s3, z1c2_s3;
	logic signed [ZW-1:0]  x2_s4, y2_s4, z2_s4, x2_s5, y2_s5, z2_s5;
	logic [NSH:0]          ok_s5;
	logic                  bh_s5, bh_s6, bh_s7, bh_s8, bh_s9, bh_s37;
	logic signed [NW-1:0]  xn_s6, yn_s6, zn_s6, zn_s7, zn_s8;
	logic signed [MW-1:0]  mx_s7, my_s7;
	logic signed [PW-1:0]  px_s8, py_s8;
	logic [PW-1:0]         magx_s9, magy_s9;
	logic                  negx_s9, negy_s9;
	logic [NW-2:0]         zn_s9;
	div_lane_t             dx_s10 [QB+1];
	div_lane_t             dy_s10 [QB+1];
	logic [NW-2:0]         dz_s10 [QB];
	logic                  db_s10 [QB+1];
	logic signed [QW-1:0]  qx_s37, qy_s37;
	logic signed [OUT_W-1:0] sx_s38, sy_s38;
	logic                  bh_s38;

	// Combinational stage logic.
	logic signed [R1W-1:0] ry_c, rz_c;
	logic signed [R2W-1:0] rx2_c, rz2_c;
	logic signed [ZW-1:0]  z2_c;
	logic [NSH:0]          ok_c;
	logic signed [NW-1:0]  xn_c, yn_c, zn_c;
	logic [BW-1:0]         bx_c, by_c;
	logic signed [SW-1:0]  zt_c, sumx_c, sumy_c;
	logic [PW-1:0]         magx_c, magy_c;
	logic [QW-1:0]         tx_c, ty_c;
	logic signed [QW-1:0]  qx_c, qy_c;
	logic signed [FW-1:0]  sx_c, sy_c;
	logic signed [OUT_W-1:0] sxo_c, syo_c;

	always_comb begin
		ry_c = R1W'(yc1_s1) - R1W'(zs1_s1) + R1W'(RND);
		rz_c = R1W'(ys1_s1) + R1W'(zc1_s1) + R1W'(RND);

		rx2_c = R2W'(xc2_s3) - R2W'(z1s2_s3) + R2W'(RND);
		rz2_c = R2W'(xs2_s3) + R2W'(z1c2_s3) + R2W'(RND);
		z2_c  = $signed(rz2_c[TRIG_FRAC +: ZW]) + ZW'(depth_q);

		for (int k = 0; k <= NSH; k++) begin
			ok_c[k] = lim_ok(x2_s4, k) && lim_ok(y2_s4, k) && lim_ok(z2_s4, k);
		end

		// The smallest joint shift that brings all three below the limit wins.
		xn_c = NW'(x2_s5 >>> NSH);
		yn_c = NW'(y2_s5 >>> NSH);
		zn_c = NW'(z2_s5 >>> NSH);
		for (int k = NSH; k >= 0; k--) begin
			if (ok_s5[k]) begin
				xn_c = NW'(x2_s5 >>> k);
				yn_c = NW'(y2_s5 >>> k);
				zn_c = NW'(z2_s5 >>> k);
			end
		end
		if (zn_c == '0) begin
			zn_c = NW'(1);
		end

		// Half the screen size plus half a pixel step splits into an integer part
		// and a remainder that is folded into the dividend.
		bx_c = (BW'(width_q) << S) + BW'(1);
		by_c = (BW'(height_q) << S) + BW'(1);
		zt_c = SW'(zn_s7) <<< 16;
		sumx_c = (SW'(mx_s7) <<< S) + (bx_c[0] ? zt_c : '0);
		sumy_c = -(SW'(my_s7) <<< S) + (by_c[0] ? zt_c : '0);

		magx_c = px_s8[PW-1] ? PW'(-px_s8) : PW'(px_s8);
		magy_c = py_s8[PW-1] ? PW'(-py_s8) : PW'(py_s8);

		// Floor of a negative quotient rounds away from zero when a remainder is left.
		tx_c = QW'(dx_s10[QB].q) + QW'(dx_s10[QB].rem != '0);
		ty_c = QW'(dy_s10[QB].q) + QW'(dy_s10[QB].rem != '0);
		if (dx_s10[QB].ovf) begin
			qx_c = dx_s10[QB].neg ? -QW'(QLIM) : QW'(QLIM);
		end else begin
			qx_c = dx_s10[QB].neg ? -$signed(tx_c) : $signed(QW'(dx_s10[QB].q));
		end
		if (dy_s10[QB].ovf) begin
			qy_c = dy_s10[QB].neg ? -QW'(QLIM) : QW'(QLIM);
		end else begin
			qy_c = dy_s10[QB].neg ? -$signed(ty_c) : $signed(QW'(dy_s10[QB].q));
		end

		sx_c = $signed(FW'(bx_c >> 1)) + FW'(qx_s37);
		sy_c = $signed(FW'(by_c >> 1)) + FW'(qy_s37);
		if (sx_c > FW'(OUT_MAX)) begin
			sxo_c = OUT_W'(OUT_MAX);
		end else if (sx_c < FW'(OUT_MIN)) begin
			sxo_c = OUT_W'(OUT_MIN);
		end else begin
			sxo_c = sx_c[OUT_W-1:0];
		end
		if (sy_c > FW'(OUT_MAX)) begin
			syo_c = OUT_W'(OUT_MAX);
		end else if (sy_c < FW'(OUT_MIN)) begin
			syo_c = OUT_W'(OUT_MIN);
		end else begin
			syo_c = sy_c[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				vd_s10[j] <= 1'b0;
			end
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
		end else if (adv) begin
			v_s1  <= vtx.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			vd_s10[0] <= v_s9;
			for (int j = 0; j < QB; j++) begin
				vd_s10[j+1] <= vd_s10[j];
			end
			v_s37 <= vd_s10[QB];
			v_s38 <= v_s37;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= vtx.vert_x;
			yc1_s1 <= vtx.vert_y * cos_yz_q;
			zs1_s1 <= vtx.vert_z * sin_yz_q;
			ys1_s1 <= vtx.vert_y * sin_yz_q;
			zc1_s1 <= vtx.vert_z * cos_yz_q;

			x_s2  <= x_s1;
			y1_s2 <= ry_c[TRIG_FRAC +: Y1W];
			z1_s2 <= rz_c[TRIG_FRAC +: Y1W];

			y1_s3   <= y1_s2;
			xc2_s3  <= x_s2 * cos_xz_q;
			xs2_s3  <= x_s2 * sin_xz_q;
			z1s2_s3 <= z1_s2 * sin_xz_q;
			z1c2_s3 <= z1_s2 * cos_xz_q;

			x2_s4 <= rx2_c[TRIG_FRAC +: ZW];
			y2_s4 <= ZW'(y1_s3);
			z2_s4 <= z2_c;

			x2_s5 <= x2_s4;
			y2_s5 <= y2_s4;
			z2_s5 <= z2_s4;
			ok_s5 <= ok_c;
			bh_s5 <= (z2_s4 <= 0);

			xn_s6 <= xn_c;
			yn_s6 <= yn_c;
			zn_s6 <= zn_c;
			bh_s6 <= bh_s5;

			mx_s7 <= $signed({1'b0, fh_q}) * xn_s6;
			my_s7 <= $signed({1'b0, fh_q}) * yn_s6;
			zn_s7 <= zn_s6;
			bh_s7 <= bh_s6;

			px_s8 <= sumx_c[17 +: PW];
			py_s8 <= sumy_c[17 +: PW];
			zn_s8 <= zn_s7;
			bh_s8 <= bh_s7;

			magx_s9 <= magx_c;
			magy_s9 <= magy_c;
			negx_s9 <= px_s8[PW-1];
			negy_s9 <= py_s8[PW-1];
			zn_s9   <= zn_s8[NW-2:0];
			bh_s9   <= bh_s8;

			// One quotient bit per stage, most significant first.
			dx_s10[0] <= div_init(magx_s9, negx_s9, zn_s9);
			dy_s10[0] <= div_init(magy_s9, negy_s9, zn_s9);
			dz_s10[0] <= zn_s9;
			db_s10[0] <= bh_s9;
			for (int j = 0; j < QB; j++) begin
				dx_s10[j+1] <= div_step(dx_s10[j], dz_s10[j], QB - 1 - j);
				dy_s10[j+1] <= div_step(dy_s10[j], dz_s10[j], QB - 1 - j);
				db_s10[j+1] <= db_s10[j];
			end
			for (int j = 0; j < QB - 1; j++) begin
				dz_s10[j+1] <= dz_s10[j];
			end

			qx_s37 <= qx_c;
			qy_s37 <= qy_c;
			bh_s37 <= db_s10[QB];

			sx_s38 <= bh_s37 ? '0 : sxo_c;
			sy_s38 <= bh_s37 ? '0 : syo_c;
			bh_s38 <= bh_s37;
		end
	end

	assign pix.valid         = v_s38;
	assign pix.screen_x      = sx_s38;
	assign pix.screen_y      = sy_s38;
	assign pix.behind_camera = bh_s38;

endmodule

[tb/vertex_rotate_project_viewport_unit_tb.sv]
// Self-checking testbench for the vertex rotate, project and viewport unit.
module vertex_rotate_project_viewport_unit_tb
	import vrp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = 16;
	localparam int PIPE_LAT = 38;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int RAND_PER_PHASE = 88;
	localparam int NUM_PHASES = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic                    behind;
	} pixel_t;
	typedef struct {
		coord_t x, y, z;
		bit     typed;
		pixel_t want;
	} vertex_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	vrp_vtx_if #(.COORD_WIDTH(COORD_W)) vtx_ch ();
	vrp_pix_if pix_ch ();

	vertex_rotate_project_viewport_unit #(.COORD_WIDTH(COORD_W), .SCREEN_FRAC_BITS(4)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .vtx(vtx_ch), .pix(pix_ch)
	);

	initial begin
		vtx_ch.valid = 1'b0;
		vtx_ch.vert_x = '0;
		vtx_ch.vert_y = '0;
		vtx_ch.vert_z = '0;
		pix_ch.ready = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the configuration registers.
	logic signed [15:0] m_cos_yz = RST_COS, m_sin_yz = RST_SIN;
	logic signed [15:0] m_cos_xz = RST_COS, m_sin_xz = RST_SIN;
	logic signed [15:0] m_depth = RST_DEPTH;
	logic [SCREEN_W-1:0] m_width = RST_WIDTH, m_height = RST_HEIGHT;

	pixel_t pending_pixels[$];
	int errors = 0;
	int vertices_sent = 0;
	int pixels_seen = 0;
	int behind_seen = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	function automatic longint round_q14(longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic longint div_floor(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
		if (v > OUT_MAX)
			return OUT_W'(OUT_MAX);
		if (v < OUT_MIN)
			return OUT_W'(OUT_MIN);
		return v[OUT_W-1:0];
	endfunction

	function automatic pixel_t project_vertex(coord_t vx, coord_t vy, coord_t vz);
		longint x, y, z, y1, z1, x2, z2, w, h, den, half, num;
		pixel_t p;
		x = vx;
		y = vy;
		z = vz;
		w = m_width;
		h = m_height;
		y1 = round_q14(y * m_cos_yz - z * m_sin_yz);
		z1 = round_q14(y * m_sin_yz + z * m_cos_yz);
		x2 = round_q14(x * m_cos_xz - z1 * m_sin_xz);
		z2 = round_q14(x * m_sin_xz + z1 * m_cos_xz) + m_depth;
		if (z2 <= 0) begin
			p.sx = '0;
			p.sy = '0;
			p.behind = 1'b1;
			return p;
		end
		// Joint scaling keeps the ratios while bounding the products.
		while ((x2 >= 2**24 || x2 <= -(2**24)) || (y1 >= 2**24 || y1 <= -(2**24))
				|| z2 >= 2**24) begin
			x2 = x2 >>> 1;
			y1 = y1 >>> 1;
			z2 = z2 >>> 1;
		end
		if (z2 == 0)
			z2 = 1;
		den = z2 <<< 17;
		half = z2 <<< 16;
		num = ((w * z2 <<< 16) + x2 * 113512 * h) <<< 4;
		p.sx = clamp_out(div_floor(num + half, den));
		num = ((h * z2 <<< 16) - y1 * 113512 * h) <<< 4;
		p.sy = clamp_out(div_floor(num + half, den));
		p.behind = 1'b0;
		return p;
	endfunction

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_COS_YZ:        m_cos_yz = d;
			REG_SIN_YZ:        m_sin_yz = d;
			REG_COS_XZ:        m_cos_xz = d;
			REG_SIN_XZ:        m_sin_xz = d;
			REG_DEPTH_SHIFT:   m_depth = d;
			REG_SCREEN_WIDTH:  m_width = d[SCREEN_W-1:0];
			REG_SCREEN_HEIGHT: m_height = d[SCREEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_all(int cy, int sy, int cx, int sx, int dz, int w, int h);
		cfg_write(REG_COS_YZ, cy[15:0]);
		cfg_write(REG_SIN_YZ, sy[15:0]);
		cfg_write(REG_COS_XZ, cx[15:0]);
		cfg_write(REG_SIN_XZ, sx[15:0]);
		cfg_write(REG_DEPTH_SHIFT, dz[15:0]);
		cfg_write(REG_SCREEN_WIDTH, w[15:0]);
		cfg_write(REG_SCREEN_HEIGHT, h[15:0]);
		cfg_we <= 1'b0;
	endtask

	task automatic send_vertex(coord_t x, coord_t y, coord_t z, bit typed, pixel_t want);
		while (!no_idle && $urandom_range(99) < 16) begin
			vtx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.vert_x <= x;
		vtx_ch.vert_y <= y;
		vtx_ch.vert_z <= z;
		do
			@(posedge clk);
		while (!vtx_ch.ready);
		pending_pixels = {pending_pixels, (typed ? want : project_vertex(x, y, z))};
		vertices_sent++;
	endtask

	task automatic wait_drained();
		vtx_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	function automatic coord_t random_coord();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return coord_t'($urandom_range(32768) - 16384);
		if (r < 85)
			return coord_t'($urandom);
		case ($urandom_range(3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic int random_trig();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	// Receiver: random back pressure plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			pix_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			pix_ch.ready <= 1'b0;
			hold_left <= LONG_HOLD;
		end else begin
			pix_ch.ready <= no_idle || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (pix_ch.valid && pix_ch.ready) begin
			pixel_t want, got;
			got.sx = pix_ch.screen_x;
			got.sy = pix_ch.screen_y;
			got.behind = pix_ch.behind_camera;
			pixels_seen++;
			behind_seen += got.behind;
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected request sx=%0d sy=%0d behind=%0b",
					$realtime, got.sx, got.sy, got.behind);
			end else begin
				want = pending_pixels.pop_front();
				if (got.sx !== want.sx) begin
					errors++;
					$display("%0t: screen_x expected %0d actual %0d", $realtime, want.sx, got.sx);
				end
				if (got.sy !== want.sy) begin
					errors++;
					$display("%0t: screen_y expected %0d actual %0d", $realtime, want.sy, got.sy);
				end
				if (got.behind !== want.behind) begin
					errors++;
					$display("%0t: behind_camera expected %0b actual %0b",
						$realtime, want.behind, got.behind);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vtx_ch.valid && vtx_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d requests still outstanding",
				$realtime, pending_pixels.size());
			$display("FAIL");
			$finish;
		end
	end

	vertex_row_t directed[] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, '{24'sd5120, 24'sd3840, 1'b0}},
		'{16'sd0, 16'sd0, -16'sd12288, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
		'{16'sd0, 16'sd0, -16'sd32768, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'sd32767, -16'sd32768, 16'sd0, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{-16'sd32768, 16'sd32767, -16'sd12287, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'sd4096, 16'sd0, 16'sd0, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'sd0, 16'sd4096, 16'sd4096, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'sd1, -16'sd1, 16'sd1, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'sh5555, 16'shaaaa, 16'sh0f0f, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{16'shaaaa, 16'sh5555, 16'sh70f0, 1'b0, '{24'sd0, 24'sd0, 1'b0}}
	};

	initial begin
		pixel_t none;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i])
			send_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
				directed[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: ;
				1: cfg_all(-16384, 16384, 16384, -16384, 32767, 4096, 4096);
				2: cfg_all(11585, 11585, 14189, 8192, -32768, 1, 1);
				3: begin
					// Out-of-range register values are used as given; unused index is ignored.
					cfg_write(cfg_reg_t'(CFG_IDX_UNUSED), 16'h1234);
					cfg_all(-32768, 32767, -32768, 16384, 0, 0, 8191);
				end
				4: cfg_all(16384, 0, 16384, 0, 1, 4096, 1);
				default: cfg_all(random_trig(), random_trig(), random_trig(), random_trig(),
					int'($urandom_range(65535)) - 32768, $urandom_range(4096, 1),
					$urandom_range(4096, 1));
			endcase
			no_idle = (ph == 6);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 5 && n == 10)
					hold_req <= 1'b1;
				else if (ph == 5 && n == 11)
					hold_req <= 1'b0;
				send_vertex(random_coord(), random_coord(), random_coord(), 1'b0, none);
			end
			no_idle = 1'b0;
		end
		hold_req <= 1'b0;
		wait_drained();

		$display("Sent %0d vertices over %0d register settings; %0d results checked.",
			vertices_sent, NUM_PHASES, pixels_seen);
		$display("%0d results were behind the camera; %0d mismatches.", behind_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[vertex_rotate_project_viewport_unit.f]
design/vrp_pkg.sv
design/vrp_if.sv
design/vertex_rotate_project_viewport_unit.sv
tb/vertex_rotate_project_viewport_unit_tb.sv
